// File: src/assert_macros.svh
// Assertion helpers used by the checker file stq_checker.sv.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sleep timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Table geometry
  localparam int SLOTS          = 32;
  localparam int THREAD_ID_BITS = 8;
  localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W          = $clog2(SLOTS + 1);

  // Field widths fixed by the interface
  localparam int TID_W  = 8;
  localparam int TIME_W = 64;
  localparam int ELAP_W = 32;

  // Thread ids keep only their low THREAD_ID_BITS bits
  localparam logic [TID_W-1:0] ID_MASK =
    (THREAD_ID_BITS >= TID_W) ? {TID_W{1'b1}} : TID_W'((1 << THREAD_ID_BITS) - 1);

  // Operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [TID_W-1:0]  thread;
    logic [TIME_W-1:0] wake;
  } entry_t;

endpackage

// File: src/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sleep_timeout_queue.sv
// ----------------------------------------------------------------------------
// sleep_timeout_queue
// System time plus a bounded table of sleeping threads; ticks wake expired
// threads in wake-time order, sleep requests insert, cancels remove.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start / busy         | op, elapsed_ns, slice_expiry, thread_id,
//           |                      | wake_time
//  result   | done (one-cycle)     | woken_valid, woken_thread, preempt, accepted,
//           |                      | table_full, found, last
//
// A cancel scans until its thread is found or the table ends; a tick makes one
// full pass per woken thread plus a final pass, each walking the entry memory
// one slot per cycle through the single wake-time comparator. The final result
// of a transaction is on the ports in the first cycle with busy low again.
// rst is synchronous; it clears the time and all valid bits, no memory sweep.
// Results cannot be held off; busy stays high until the last one is issued.
// ----------------------------------------------------------------------------
module sleep_timeout_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [stq_pkg::ELAP_W-1:0] elapsed_ns,
  input  logic [stq_pkg::TIME_W-1:0] slice_expiry,
  input  logic [stq_pkg::TID_W-1:0]  thread_id,
  input  logic [stq_pkg::TIME_W-1:0] wake_time,
  output logic                      done,
  output logic                      woken_valid,
  output logic [stq_pkg::TID_W-1:0]  woken_thread,
  output logic                      preempt,
  output logic                      accepted,
  output logic                      table_full,
  output logic                      found,
  output logic                      last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TSCAN = 4'b0010,
    ST_SLEEP = 4'b0100,
    ST_CSCAN = 4'b1000
  } state_t;

  state_t                       state;
  logic [stq_pkg::TIME_W-1:0]   current_time;
  logic [stq_pkg::SLOTS-1:0]    slot_valid;

  // Latched command
  logic [stq_pkg::TID_W-1:0]    tid_q;
  logic [stq_pkg::TIME_W-1:0]   wake_q;
  logic [stq_pkg::TIME_W-1:0]   slice_q;

  // Scan sequencer
  logic [stq_pkg::CNT_W-1:0]    scan_cnt;
  logic                         cmp_vld;
  logic [stq_pkg::SLOT_W-1:0]   cmp_idx;
  logic                         best_vld;
  logic [stq_pkg::SLOT_W-1:0]   best_idx;
  logic [stq_pkg::TIME_W-1:0]   best_wake;
  logic [stq_pkg::TID_W-1:0]    best_thread;
  logic                         pend_vld;
  logic [stq_pkg::TID_W-1:0]    pend_thread;

  // Memory ports
  logic                         ram_we;
  logic [stq_pkg::SLOT_W-1:0]   ram_waddr;
  stq_pkg::entry_t              ram_wdata;
  stq_pkg::entry_t              ram_rdata;

  logic                         accept;
  logic                         rd_issue;
  logic                         scan_end;
  logic                         due_hit;
  logic                         cancel_hit;
  logic                         pre;
  logic                         sleep_past;
  logic                         any_free;
  logic [stq_pkg::SLOT_W-1:0]   free_idx;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Scan control: one read per cycle, compared in the cycle after
  assign rd_issue = (state == ST_TSCAN || state == ST_CSCAN) &&
                    (scan_cnt != stq_pkg::CNT_W'(stq_pkg::SLOTS));
  assign scan_end = (scan_cnt == stq_pkg::CNT_W'(stq_pkg::SLOTS)) && !cmp_vld;

  // Shared comparator: expired and earlier than the best so far
  assign due_hit = cmp_vld && slot_valid[cmp_idx] &&
                   (ram_rdata.wake <= current_time) &&
                   (!best_vld || (ram_rdata.wake < best_wake));

  assign cancel_hit = cmp_vld && slot_valid[cmp_idx] && (ram_rdata.thread == tid_q);

  assign pre        = (slice_q != '0) && (slice_q <= current_time);
  assign sleep_past = (wake_q < current_time);

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = stq_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = stq_pkg::SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign ram_we           = (state == ST_SLEEP) && !sleep_past && any_free;
  assign ram_waddr        = free_idx;
  assign ram_wdata.thread = tid_q;
  assign ram_wdata.wake   = wake_q;

  stq_ram #(
    .WIDTH ($bits(stq_pkg::entry_t)),
    .DEPTH (stq_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt[stq_pkg::SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_time <= '0;
      slot_valid   <= '0;
      scan_cnt     <= '0;
      cmp_vld      <= 1'b0;
      best_vld     <= 1'b0;
      pend_vld     <= 1'b0;
      done         <= 1'b0;
    end else begin
      // result defaults: nothing issued this cycle
      done         <= 1'b0;
      woken_valid  <= 1'b0;
      woken_thread <= '0;
      preempt      <= 1'b0;
      accepted     <= 1'b0;
      table_full   <= 1'b0;
      found        <= 1'b0;
      last         <= 1'b0;

      cmp_vld <= rd_issue;
      cmp_idx <= scan_cnt[stq_pkg::SLOT_W-1:0];
      if (rd_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            tid_q    <= thread_id & stq_pkg::ID_MASK;
            wake_q   <= wake_time;
            slice_q  <= slice_expiry;
            scan_cnt <= '0;
            best_vld <= 1'b0;
            pend_vld <= 1'b0;
            case (op)
              stq_pkg::OP_TICK: begin
                current_time <= current_time + stq_pkg::TIME_W'(elapsed_ns);
                state        <= ST_TSCAN;
              end
              stq_pkg::OP_SLEEP:  state <= ST_SLEEP;
              stq_pkg::OP_CANCEL: state <= ST_CSCAN;
              default: begin
                // unused code: a bare final result
                done <= 1'b1;
                last <= 1'b1;
              end
            endcase
          end
        end

        ST_TSCAN: begin
          if (due_hit) begin
            best_vld    <= 1'b1;
            best_idx    <= cmp_idx;
            best_wake   <= ram_rdata.wake;
            best_thread <= ram_rdata.thread;
          end
          if (scan_end) begin
            if (best_vld) begin
              // earliest expired entry found: retire it, issue the one held
              slot_valid[best_idx] <= 1'b0;
              if (pend_vld) begin
                done         <= 1'b1;
                woken_valid  <= 1'b1;
                woken_thread <= pend_thread;
              end
              pend_vld    <= 1'b1;
              pend_thread <= best_thread;
              best_vld    <= 1'b0;
              scan_cnt    <= '0;
            end else begin
              // nothing else due: final result of the tick
              done         <= 1'b1;
              woken_valid  <= pend_vld;
              woken_thread <= pend_vld ? pend_thread : '0;
              preempt      <= pre;
              last         <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end

        ST_SLEEP: begin
          done  <= 1'b1;
          last  <= 1'b1;
          state <= ST_IDLE;
          if (!sleep_past) begin
            if (any_free) begin
              slot_valid[free_idx] <= 1'b1;
              accepted             <= 1'b1;
            end else begin
              table_full <= 1'b1;
            end
          end
        end

        ST_CSCAN: begin
          if (cancel_hit) begin
            slot_valid[cmp_idx] <= 1'b0;
            done                <= 1'b1;
            found               <= 1'b1;
            last                <= 1'b1;
            cmp_vld             <= 1'b0;
            state               <= ST_IDLE;
          end else if (scan_end) begin
            done  <= 1'b1;
            last  <= 1'b1;
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sleep timeout queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stq_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       done,
  input logic       woken_valid,
  input logic       accepted,
  input logic       table_full,
  input logic       found,
  input logic       last
);

  // a sleep transaction is never both stored and refused as full
  `ASSERT_IMPLY(a_sleep_excl, clk, rst, done && accepted, !table_full)

  // sleep and cancel results always close their transaction
  `ASSERT_IMPLY(a_single_last, clk, rst, done && (accepted || table_full || found), last)

  // a non-final result is a wakeup, and the block is still working
  `ASSERT_IMPLY(a_mid_tick, clk, rst, done && !last, woken_valid && busy)

  // an unused opcode answers in the next cycle with a bare final result
  `ASSERT_NEXT(a_nop, clk, rst, start && !busy && (op == stq_pkg::OP_NOP),
               done && last && !woken_valid)

  // a tick, sleep or cancel makes the block busy in the next cycle
  `ASSERT_NEXT(a_busy, clk, rst, start && !busy && (op != stq_pkg::OP_NOP), busy)

endmodule

bind sleep_timeout_queue stq_checker u_stq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .op          (op),
  .done        (done),
  .woken_valid (woken_valid),
  .accepted    (accepted),
  .table_full  (table_full),
  .found       (found),
  .last        (last)
);
